FILE: sv/pfdc_pkg.sv
// ----------------------------------------------------------------------------
// pfdc_pkg
// Shared types, constants and the component-select table for the
// pixel-format descriptor check.
// ----------------------------------------------------------------------------
package pfdc_pkg;

    localparam int unsigned COMPONENTS = 4;
    localparam int unsigned FIELD_W    = 8;
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned RFLAGS_W   = 9;

    localparam int unsigned LANE_RED   = 0;
    localparam int unsigned LANE_GREEN = 1;
    localparam int unsigned LANE_BLUE  = 2;
    localparam int unsigned LANE_ALPHA = 3;

    localparam int unsigned FLAG_ALPHA   = 1;
    localparam int unsigned FLAG_LUM     = 2;
    localparam int unsigned FLAG_INDEXED = 4;
    localparam int unsigned FLAG_PREMUL  = 5;
    localparam int unsigned FLAG_SWAP    = 6;
    localparam int unsigned FLAG_PALETTE = 7;
    localparam int unsigned FLAG_ALIGNED = 8;

    localparam logic [FIELD_W-1:0] MAX_SIZE      = 8'd16;
    localparam logic [FIELD_W-1:0] BYTE_SIZE     = 8'd8;
    localparam logic [FIELD_W-1:0] MAX_IDX_DEPTH = 8'd8;

    localparam logic [COMPONENTS-1:0] SEL_NONE = 4'h0;
    localparam logic [COMPONENTS-1:0] SEL_RGB  = 4'h7;
    localparam logic [COMPONENTS-1:0] SEL_A    = 4'h8;
    localparam logic [COMPONENTS-1:0] SEL_RGBA = 4'hF;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [MASK_W-1:0]  mask_t;

    typedef struct packed {
        logic   bad;
        logic   unaligned;
        logic   crosses;
        mask_t  mask;
        field_t swap_shift;
    } lane_info_t;

    typedef struct packed {
        field_t                          depth;
        field_t                          flags;
        logic                            sel_none;
        logic                            rgb_equal;
        lane_info_t [COMPONENTS-1:0]     lanes;
        logic [COMPONENTS-1:0][FIELD_W-1:0] shifts;
    } stage_t;

    typedef struct packed {
        logic                               status;
        logic [RFLAGS_W-1:0]                result_flags;
        logic                               undefined_bits;
        logic [COMPONENTS-1:0][FIELD_W-1:0] shift_out;
    } result_t;

    function automatic logic [COMPONENTS-1:0] comp_sel(input logic [3:0] code);
        logic [COMPONENTS-1:0] sel;
        case (code)
            4'd1:    sel = SEL_RGB;
            4'd2:    sel = SEL_A;
            4'd3:    sel = SEL_RGBA;
            4'd4:    sel = SEL_RGB;
            4'd6:    sel = SEL_RGBA;
            default: sel = SEL_NONE;
        endcase
        return sel;
    endfunction

    function automatic logic depth_ok(input field_t d);
        logic ok;
        case (d)
            8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd24, 8'd32: ok = 1'b1;
            default:                                      ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

FILE: sv/pfdc_desc_if.sv
// ----------------------------------------------------------------------------
// pfdc_desc_if
// Descriptor channel: valid/ready handshake with the descriptor fields.
// ----------------------------------------------------------------------------
interface pfdc_desc_if;
    logic         valid;
    logic         ready;
    logic [7:0]   depth_bits;
    logic [7:0]   format_flags;
    logic [7:0]   red_size;
    logic [7:0]   green_size;
    logic [7:0]   blue_size;
    logic [7:0]   alpha_size;
    logic [7:0]   red_shift;
    logic [7:0]   green_shift;
    logic [7:0]   blue_shift;
    logic [7:0]   alpha_shift;

    modport source (
        output valid, depth_bits, format_flags, red_size, green_size, blue_size,
               alpha_size, red_shift, green_shift, blue_shift, alpha_shift,
        input  ready
    );
    modport sink (
        input  valid, depth_bits, format_flags, red_size, green_size, blue_size,
               alpha_size, red_shift, green_shift, blue_shift, alpha_shift,
        output ready
    );
endinterface

FILE: sv/pfdc_result_if.sv
// ----------------------------------------------------------------------------
// pfdc_result_if
// Result channel: valid/ready handshake with the check result fields.
// ----------------------------------------------------------------------------
interface pfdc_result_if;
    logic         valid;
    logic         ready;
    logic         status;
    logic [8:0]   result_flags;
    logic         undefined_bits;
    logic [7:0]   red_shift_out;
    logic [7:0]   green_shift_out;
    logic [7:0]   blue_shift_out;
    logic [7:0]   alpha_shift_out;

    modport source (
        output valid, status, result_flags, undefined_bits, red_shift_out,
               green_shift_out, blue_shift_out, alpha_shift_out,
        input  ready
    );
    modport sink (
        input  valid, status, result_flags, undefined_bits, red_shift_out,
               green_shift_out, blue_shift_out, alpha_shift_out,
        output ready
    );
endinterface

FILE: sv/pfdc_lane.sv
// ----------------------------------------------------------------------------
// pfdc_lane
// Per-component check: presence, size and range, alignment, byte crossing,
// bit mask of the field and the byte-swapped shift.
// ----------------------------------------------------------------------------
module pfdc_lane (
    input  pfdc_pkg::field_t     depth,
    input  logic                 sel_bit,
    input  pfdc_pkg::field_t     size,
    input  pfdc_pkg::field_t     shift,
    output pfdc_pkg::lane_info_t info
);

    logic                    present;
    logic [8:0]              span_end;
    logic [8:0]              last_bit;
    logic                    fits;
    pfdc_pkg::mask_t         ones;

    assign present  = (size != '0);
    assign span_end = {1'b0, shift} + {1'b0, size};
    assign last_bit = span_end - 9'd1;
    assign fits     = (span_end <= {1'b0, depth});

    always_comb
    begin
        if (size >= 8'(pfdc_pkg::MASK_W))
            ones = '1;
        else
            ones = (pfdc_pkg::MASK_W'(1) << size[4:0]) - pfdc_pkg::MASK_W'(1);
    end

    always_comb
    begin
        if (present)
            info.bad = !sel_bit || (size > pfdc_pkg::MAX_SIZE) || !fits;
        else
            info.bad = sel_bit || (shift != '0);
        info.unaligned  = present && ((size != pfdc_pkg::BYTE_SIZE) || (shift[2:0] != 3'd0));
        info.crosses    = present && (last_bit[8:3] != {1'b0, shift[7:3]});
        info.mask       = present ? (ones << shift) : '0;
        info.swap_shift = depth - shift - size;
    end

endmodule

FILE: sv/pfdc_merge.sv
// ----------------------------------------------------------------------------
// pfdc_merge
// Combine the lane findings: overlap and coverage, global checks, flag
// normalization and byte-swap folding into the final result.
// ----------------------------------------------------------------------------
module pfdc_merge (
    input  pfdc_pkg::stage_t  stage,
    output pfdc_pkg::result_t item
);

    localparam int unsigned N = pfdc_pkg::COMPONENTS;

    logic            indexed;
    logic            lum;
    logic            any_bad;
    logic            any_cross;
    logic            any_unaligned;
    logic            overlap;
    logic            alpha_overlap;
    logic            invalid;
    logic            undef;
    logic            do_fold;
    pfdc_pkg::mask_t combined;
    pfdc_pkg::mask_t full;
    pfdc_pkg::field_t flags;

    assign indexed = stage.flags[pfdc_pkg::FLAG_INDEXED];
    assign lum     = stage.flags[pfdc_pkg::FLAG_LUM];

    always_comb
    begin
        any_bad       = 1'b0;
        any_cross     = 1'b0;
        any_unaligned = 1'b0;
        overlap       = 1'b0;
        alpha_overlap = 1'b0;
        combined      = '0;
        for (int i = 0; i < N; i++)
        begin
            any_bad       = any_bad | stage.lanes[i].bad;
            any_cross     = any_cross | stage.lanes[i].crosses;
            any_unaligned = any_unaligned | stage.lanes[i].unaligned;
            combined      = combined | stage.lanes[i].mask;
            for (int j = 0; j < i; j++)
            begin
                if ((stage.lanes[i].mask & stage.lanes[j].mask) != '0)
                begin
                    overlap = 1'b1;
                    if (i == pfdc_pkg::LANE_ALPHA)
                        alpha_overlap = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (stage.depth >= 8'(pfdc_pkg::MASK_W))
            full = '1;
        else
            full = (pfdc_pkg::MASK_W'(1) << stage.depth[4:0]) - pfdc_pkg::MASK_W'(1);
    end

    assign undef = (combined != full);

    always_comb
    begin
        if (!pfdc_pkg::depth_ok(stage.depth))
            invalid = 1'b1;
        else if (indexed)
            invalid = (stage.depth > pfdc_pkg::MAX_IDX_DEPTH) ||
                      !stage.flags[pfdc_pkg::FLAG_PALETTE];
        else
            invalid = stage.sel_none || any_bad || alpha_overlap ||
                      (lum != overlap) || (lum && !stage.rgb_equal);
    end

    always_comb
    begin
        flags   = stage.flags;
        do_fold = 1'b0;
        if (!indexed && !stage.flags[pfdc_pkg::FLAG_ALPHA])
            flags[pfdc_pkg::FLAG_PREMUL] = 1'b0;
        if (stage.flags[pfdc_pkg::FLAG_SWAP])
        begin
            if (stage.depth <= pfdc_pkg::MAX_IDX_DEPTH)
                flags[pfdc_pkg::FLAG_SWAP] = 1'b0;
            else if (indexed || !any_cross)
            begin
                flags[pfdc_pkg::FLAG_SWAP] = 1'b0;
                do_fold                    = 1'b1;
            end
        end

        item = '0;
        if (invalid)
        begin
            item.status = 1'b1;
        end
        else
        begin
            item.status       = 1'b0;
            item.result_flags = {indexed || !any_unaligned, flags};
            item.undefined_bits = !indexed && undef;
            for (int i = 0; i < N; i++)
            begin
                if (do_fold && (stage.lanes[i].mask != '0))
                    item.shift_out[i] = stage.lanes[i].swap_shift;
                else
                    item.shift_out[i] = stage.shifts[i];
            end
        end
    end

endmodule

FILE: sv/pixel_format_descriptor_check.sv
// ----------------------------------------------------------------------------
// pixel_format_descriptor_check
// Validates a pixel-format descriptor and returns it in normalized form.
// ----------------------------------------------------------------------------
// One result per descriptor, in order. A new descriptor is taken every cycle
// while the sink keeps up. There are two register stages: one after the four
// component lanes and one output register after the merge stage. A descriptor
// that transfers in passes the lane register and then the output register.
// While a result waits for the sink, the lane stage takes one more descriptor
// and then holds. Input ready then stays low until the sink takes the result.
// ----------------------------------------------------------------------------
module pixel_format_descriptor_check (
    input  logic           clk,
    input  logic           rst_n,
    pfdc_desc_if.sink      desc,
    pfdc_result_if.source  result
);

    localparam int unsigned N = pfdc_pkg::COMPONENTS;

    pfdc_pkg::field_t              size_in  [N];
    pfdc_pkg::field_t              shift_in [N];
    logic [N-1:0]                  sel;
    pfdc_pkg::lane_info_t          lane_info [N];
    pfdc_pkg::stage_t              s1_next;
    pfdc_pkg::stage_t              s1_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    pfdc_pkg::result_t             merged;
    pfdc_pkg::result_t             out_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          s1_ready;
    logic                          out_ready;
    logic                          s1_load;
    logic                          out_load;

    assign size_in[pfdc_pkg::LANE_RED]    = desc.red_size;
    assign size_in[pfdc_pkg::LANE_GREEN]  = desc.green_size;
    assign size_in[pfdc_pkg::LANE_BLUE]   = desc.blue_size;
    assign size_in[pfdc_pkg::LANE_ALPHA]  = desc.alpha_size;
    assign shift_in[pfdc_pkg::LANE_RED]   = desc.red_shift;
    assign shift_in[pfdc_pkg::LANE_GREEN] = desc.green_shift;
    assign shift_in[pfdc_pkg::LANE_BLUE]  = desc.blue_shift;
    assign shift_in[pfdc_pkg::LANE_ALPHA] = desc.alpha_shift;

    assign sel = pfdc_pkg::comp_sel(desc.format_flags[3:0]);

    for (genvar g = 0; g < N; g++)
    begin : g_lane
        pfdc_lane u_lane (
            .depth   (desc.depth_bits),
            .sel_bit (sel[g]),
            .size    (size_in[g]),
            .shift   (shift_in[g]),
            .info    (lane_info[g])
        );
    end

    always_comb
    begin
        s1_next.depth     = desc.depth_bits;
        s1_next.flags     = desc.format_flags;
        s1_next.sel_none  = (sel == pfdc_pkg::SEL_NONE);
        s1_next.rgb_equal = (desc.red_size == desc.green_size) &&
                            (desc.red_shift == desc.green_shift) &&
                            (desc.green_size == desc.blue_size) &&
                            (desc.green_shift == desc.blue_shift);
        for (int i = 0; i < N; i++)
        begin
            s1_next.lanes[i]  = lane_info[i];
            s1_next.shifts[i] = shift_in[i];
        end
    end

    pfdc_merge u_merge (
        .stage (s1_reg),
        .item  (merged)
    );

    assign out_ready      = !out_valid_reg || result.ready;
    assign s1_ready       = !s1_valid_reg || out_ready;
    assign s1_load        = desc.valid && s1_ready;
    assign out_load       = s1_valid_reg && out_ready;
    assign s1_valid_next  = s1_ready ? desc.valid : s1_valid_reg;
    assign out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_reg <= s1_next;
        if (out_load)
            out_reg <= merged;
    end

    assign desc.ready             = s1_ready;
    assign result.valid           = out_valid_reg;
    assign result.status          = out_reg.status;
    assign result.result_flags    = out_reg.result_flags;
    assign result.undefined_bits  = out_reg.undefined_bits;
    assign result.red_shift_out   = out_reg.shift_out[pfdc_pkg::LANE_RED];
    assign result.green_shift_out = out_reg.shift_out[pfdc_pkg::LANE_GREEN];
    assign result.blue_shift_out  = out_reg.shift_out[pfdc_pkg::LANE_BLUE];
    assign result.alpha_shift_out = out_reg.shift_out[pfdc_pkg::LANE_ALPHA];

endmodule
